// ===== design/adsr_pkg.sv =====
package adsr_pkg;

	// field and state widths
	localparam int DUR_W   = 22;
	localparam int SMP_W   = 16;
	localparam int LVL_W   = 16;
	localparam int TICK_W  = DUR_W + 1;
	localparam int CFG_ADDR_W = 3;

	// serial multiplier: multiplicand x one multiplier bit per cycle
	localparam int MUL_A_W   = (TICK_W > LVL_W) ? TICK_W : LVL_W;
	localparam int MUL_B_W   = LVL_W;
	localparam int PROD_W    = MUL_A_W + MUL_B_W;
	localparam int MUL_CNT_W = $clog2(MUL_B_W);

	// serial divider: one quotient bit per cycle
	localparam int QUO_W     = LVL_W;
	localparam int REM_W     = PROD_W - QUO_W;
	localparam int DIV_CNT_W = $clog2(QUO_W);

	localparam logic [LVL_W-1:0] FULL_SCALE = {LVL_W{1'b1}};

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_ATTACK  = 3'd0,
		REG_DECAY   = 3'd1,
		REG_SUSTAIN = 3'd2,
		REG_RELEASE = 3'd3,
		REG_VOLUME  = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_SAMPLE  = 2'd0,
		MODE_TRIGGER = 2'd1,
		MODE_RELEASE = 2'd2
	} mode_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	// x / 65535 for x <= 65535*65535: x = q*65536 + lo = q*65535 + (q + lo)
	function automatic logic [LVL_W-1:0] div_full_scale(input logic [2*LVL_W-1:0] x);
		logic [LVL_W-1:0] q;
		logic [LVL_W:0]   r;
		q = x[2*LVL_W-1:LVL_W];
		r = {1'b0, x[LVL_W-1:0]} + {1'b0, q};
		div_full_scale = q + ((r >= {1'b0, FULL_SCALE}) ? LVL_W'(1) : LVL_W'(0));
	endfunction

endpackage

// ===== design/adsr_mul.sv =====
module adsr_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [adsr_pkg::MUL_A_W-1:0]  a,
	input  logic [adsr_pkg::MUL_B_W-1:0]  b,
	output adsr_pkg::unit_stat_t          stat,
	output logic [adsr_pkg::PROD_W-1:0]   product
);

	// {partial high word, remaining multiplier bits}
	logic [adsr_pkg::PROD_W-1:0]          p_q;
	logic [adsr_pkg::MUL_A_W-1:0]         a_q;
	logic [adsr_pkg::MUL_CNT_W-1:0]       cnt_q;
	logic                                 busy_q;
	logic                                 done_q;
	logic [adsr_pkg::MUL_A_W:0]           hi_c;

	always_comb begin
		hi_c = {1'b0, p_q[adsr_pkg::PROD_W-1:adsr_pkg::MUL_B_W]};
		if (p_q[0]) begin
			hi_c = hi_c + {1'b0, a_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= adsr_pkg::MUL_CNT_W'(adsr_pkg::MUL_B_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			p_q <= {{adsr_pkg::MUL_A_W{1'b0}}, b};
		end else if (busy_q) begin
			p_q <= {hi_c, p_q[adsr_pkg::MUL_B_W-1:1]};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign product   = p_q;

endmodule

// ===== design/adsr_div.sv =====
module adsr_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [adsr_pkg::PROD_W-1:0]   num,
	input  logic [adsr_pkg::DUR_W-1:0]    den,
	output adsr_pkg::unit_stat_t          stat,
	output logic [adsr_pkg::QUO_W-1:0]    quo
);

	// restoring division; caller guarantees num < den * 2^QUO_W and den != 0
	logic [adsr_pkg::REM_W-1:0]       r_q;
	logic [adsr_pkg::QUO_W-1:0]       n_q;
	logic [adsr_pkg::DUR_W-1:0]       den_q;
	logic [adsr_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic                             busy_q;
	logic                             done_q;
	logic [adsr_pkg::REM_W:0]         t_c;
	logic [adsr_pkg::REM_W:0]         d_c;
	logic                             ge_c;
	logic [adsr_pkg::REM_W-1:0]       r_c;

	always_comb begin
		t_c  = {r_q, n_q[adsr_pkg::QUO_W-1]};
		d_c  = (adsr_pkg::REM_W + 1)'(den_q);
		ge_c = (t_c >= d_c);
		r_c  = ge_c ? adsr_pkg::REM_W'(t_c - d_c) : adsr_pkg::REM_W'(t_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= adsr_pkg::DIV_CNT_W'(adsr_pkg::QUO_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// numerator low bits shift out on top while quotient bits shift in below
	always_ff @(posedge clk) begin
		if (start) begin
			r_q   <= num[adsr_pkg::PROD_W-1:adsr_pkg::QUO_W];
			n_q   <= num[adsr_pkg::QUO_W-1:0];
			den_q <= den;
		end else if (busy_q) begin
			r_q <= r_c;
			n_q <= {n_q[adsr_pkg::QUO_W-2:0], ge_c};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo       = n_q;

endmodule

// ===== design/adsr_envelope_generator.sv =====
// sample transaction: the sequencer runs setup, numerator product (bit-serial multiplier),
// divide (bit-serial divider), scale and gain when the level needs a division (attack,
// decay, release ramps), else setup, scale and gain, then loads the output register when
// it is free and returns to idle for the next item; trigger and release never leave idle
// arst_n clears envelope phase (idle), tick count, sequencer and output valid at once;
// registers reset to attack/decay/release 0, sustain and volume 65535
module adsr_envelope_generator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [adsr_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  logic [adsr_pkg::DUR_W-1:0]        cfg_wdata,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [adsr_pkg::SMP_W-1:0]        s_axis_tdata,  // [15:0] source_sample
	input  logic [1:0]                        s_axis_tuser,  // [1:0] mode
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [adsr_pkg::LVL_W-1:0]        m_axis_tdata   // [15:0] shaped_sample
);

	typedef enum logic [4:0] {
		PH_IDLE    = 5'b00001,
		PH_ATTACK  = 5'b00010,
		PH_DECAY   = 5'b00100,
		PH_SUSTAIN = 5'b01000,
		PH_RELEASE = 5'b10000
	} phase_t;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_SETUP = 7'b0000010,
		ST_NUM   = 7'b0000100,
		ST_DIV   = 7'b0001000,
		ST_SCALE = 7'b0010000,
		ST_GAIN  = 7'b0100000,
		ST_OUT   = 7'b1000000
	} st_t;

	logic [adsr_pkg::DUR_W-1:0]   attack_q;
	logic [adsr_pkg::DUR_W-1:0]   decay_q;
	logic [adsr_pkg::LVL_W-1:0]   sustain_q;
	logic [adsr_pkg::DUR_W-1:0]   release_q;
	logic [adsr_pkg::LVL_W-1:0]   volume_q;

	phase_t                       phase_q;
	logic [adsr_pkg::TICK_W-1:0]  tick_q;
	st_t                          state_q;
	logic                         out_valid_q;
	logic [adsr_pkg::LVL_W-1:0]   out_data_q;

	// per-sample operands
	logic [adsr_pkg::LVL_W-1:0]   m_q;
	logic [adsr_pkg::TICK_W-1:0]  t_q;
	logic [adsr_pkg::DUR_W-1:0]   den_q;
	logic [adsr_pkg::LVL_W-1:0]   base_q;
	logic                         neg_q;
	logic                         div_q;
	logic [adsr_pkg::SMP_W-1:0]   sample_q;

	// envelope step decided at acceptance
	phase_t                       env_phase_c;
	logic [adsr_pkg::TICK_W-1:0]  env_tick_c;
	logic [adsr_pkg::LVL_W-1:0]   env_m_c;
	logic [adsr_pkg::DUR_W-1:0]   env_den_c;
	logic [adsr_pkg::LVL_W-1:0]   env_base_c;
	logic                         env_neg_c;
	logic                         env_div_c;
	logic [adsr_pkg::TICK_W-1:0]  tick_inc_c;

	logic                         in_acc_c;
	logic                         load_out_c;
	logic [adsr_pkg::LVL_W-1:0]   quo_c;
	logic [adsr_pkg::LVL_W-1:0]   level_c;

	logic                         mul_start_c;
	logic [adsr_pkg::MUL_A_W-1:0] mul_a_c;
	logic [adsr_pkg::MUL_B_W-1:0] mul_b_c;
	adsr_pkg::unit_stat_t         mul_stat;
	logic [adsr_pkg::PROD_W-1:0]  mul_prod;
	logic                         div_start_c;
	adsr_pkg::unit_stat_t         div_stat;
	logic [adsr_pkg::QUO_W-1:0]   div_quo;
	logic [adsr_pkg::LVL_W-1:0]   prod_scaled_c;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc_c      = s_axis_tvalid && s_axis_tready;
	assign load_out_c    = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);
	assign tick_inc_c    = tick_q + 1'b1;
	assign prod_scaled_c = adsr_pkg::div_full_scale(mul_prod[2*adsr_pkg::LVL_W-1:0]);

	always_comb begin
		env_phase_c = phase_q;
		env_tick_c  = tick_inc_c;
		env_m_c     = adsr_pkg::FULL_SCALE;
		env_den_c   = attack_q;
		env_base_c  = '0;
		env_neg_c   = 1'b1;
		env_div_c   = 1'b0;
		unique case (phase_q)
			PH_ATTACK: begin
				if (tick_q > adsr_pkg::TICK_W'(attack_q)) begin
					// first decay tick: full level
					env_phase_c = PH_DECAY;
					env_tick_c  = adsr_pkg::TICK_W'(1);
					env_base_c  = adsr_pkg::FULL_SCALE;
				end else begin
					env_neg_c = 1'b0;
					env_div_c = (attack_q != '0);
				end
			end
			PH_DECAY: begin
				env_base_c = adsr_pkg::FULL_SCALE;
				if (tick_q > adsr_pkg::TICK_W'(decay_q)) begin
					env_phase_c = PH_SUSTAIN;
					env_tick_c  = adsr_pkg::TICK_W'(1);
					env_base_c  = sustain_q;
				end else begin
					env_m_c   = adsr_pkg::FULL_SCALE - sustain_q;
					env_den_c = decay_q;
					env_div_c = (decay_q != '0);
				end
			end
			PH_SUSTAIN: begin
				env_base_c = sustain_q;
			end
			PH_RELEASE: begin
				if (tick_q > adsr_pkg::TICK_W'(release_q)) begin
					env_phase_c = PH_IDLE;
					env_tick_c  = adsr_pkg::TICK_W'(1);
				end else begin
					env_base_c = sustain_q;
					env_m_c    = sustain_q;
					env_den_c  = release_q;
					env_div_c  = (release_q != '0);
				end
			end
			default: begin
				// idle: level zero, envelope untouched
				env_tick_c = tick_q;
			end
		endcase
	end

	assign quo_c   = div_q ? div_quo : '0;
	assign level_c = neg_q ? (base_q - quo_c) : quo_c;

	always_comb begin
		mul_start_c = 1'b0;
		mul_a_c     = adsr_pkg::MUL_A_W'(sample_q);
		mul_b_c     = level_c;
		div_start_c = 1'b0;
		unique case (state_q)
			ST_SETUP: begin
				mul_start_c = 1'b1;
				if (div_q) begin
					mul_a_c = adsr_pkg::MUL_A_W'(t_q);
					mul_b_c = m_q;
				end
			end
			ST_NUM: begin
				div_start_c = mul_stat.done;
			end
			ST_DIV: begin
				mul_start_c = div_stat.done;
			end
			ST_SCALE: begin
				mul_start_c = mul_stat.done;
				mul_a_c     = adsr_pkg::MUL_A_W'(prod_scaled_c);
				mul_b_c     = volume_q;
			end
			default: begin
			end
		endcase
	end

	adsr_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start_c),
		.a       (mul_a_c),
		.b       (mul_b_c),
		.stat    (mul_stat),
		.product (mul_prod)
	);

	adsr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_c),
		.num    (mul_prod),
		.den    (den_q),
		.stat   (div_stat),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q  <= '0;
			decay_q   <= '0;
			sustain_q <= adsr_pkg::FULL_SCALE;
			release_q <= '0;
			volume_q  <= adsr_pkg::FULL_SCALE;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				adsr_pkg::REG_ATTACK:  attack_q  <= cfg_wdata;
				adsr_pkg::REG_DECAY:   decay_q   <= cfg_wdata;
				adsr_pkg::REG_SUSTAIN: sustain_q <= cfg_wdata[adsr_pkg::LVL_W-1:0];
				adsr_pkg::REG_RELEASE: release_q <= cfg_wdata;
				adsr_pkg::REG_VOLUME:  volume_q  <= cfg_wdata[adsr_pkg::LVL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			tick_q      <= '0;
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out_c) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc_c) begin
						unique case (s_axis_tuser)
							adsr_pkg::MODE_TRIGGER: begin
								phase_q <= PH_ATTACK;
								tick_q  <= '0;
							end
							adsr_pkg::MODE_RELEASE: begin
								if (phase_q == PH_ATTACK || phase_q == PH_DECAY ||
								    phase_q == PH_SUSTAIN) begin
									phase_q <= PH_RELEASE;
									tick_q  <= '0;
								end
							end
							adsr_pkg::MODE_SAMPLE: begin
								phase_q <= env_phase_c;
								tick_q  <= env_tick_c;
								state_q <= ST_SETUP;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SETUP: begin
					state_q <= div_q ? ST_NUM : ST_SCALE;
				end
				ST_NUM: begin
					if (mul_stat.done) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					if (mul_stat.done) begin
						state_q <= ST_GAIN;
					end
				end
				ST_GAIN: begin
					if (mul_stat.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (load_out_c) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc_c) begin
			m_q      <= env_m_c;
			t_q      <= tick_q;
			den_q    <= env_den_c;
			base_q   <= env_base_c;
			neg_q    <= env_neg_c;
			div_q    <= env_div_c;
			sample_q <= s_axis_tdata;
		end
		if (load_out_c) begin
			out_data_q <= prod_scaled_c;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
	a_ready_units_free: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> (!mul_stat.busy && !div_stat.busy))
		else $error("input ready while an arithmetic unit is busy");

	a_mul_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_stat.done |-> (state_q == ST_NUM || state_q == ST_SCALE || state_q == ST_GAIN))
		else $error("multiplier finished outside a multiply step");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide step");

	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("pending result overwritten");
`endif

endmodule
